// File: design/rle_cell_pattern_decoder_core_assert.svh
// Assertion macros shared by the decoder RTL.
// Expects clk_i and rst_ni to be in scope where a macro is used.
`ifndef RLE_CELL_PATTERN_DECODER_CORE_ASSERT_SVH
`define RLE_CELL_PATTERN_DECODER_CORE_ASSERT_SVH

// same-cycle implication
`define RCPD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RCPD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/rcpd_pkg.sv
// Types and constants for the RLE cell pattern decoder.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rcpd_pkg;

  // body characters
  localparam logic [7:0] CHAR_0    = 8'h30;
  localparam logic [7:0] CHAR_9    = 8'h39;
  localparam logic [7:0] CHAR_RUN  = 8'h6F; // 'o'
  localparam logic [7:0] CHAR_SKIP = 8'h62; // 'b'
  localparam logic [7:0] CHAR_ROW  = 8'h24; // '$'
  localparam logic [7:0] CHAR_END  = 8'h21; // '!'

  // config register indexes
  localparam logic CFG_BOARD_WIDTH  = 1'b0;
  localparam logic CFG_BOARD_HEIGHT = 1'b1;

  localparam logic [10:0] SIDE_RESET = 11'd1024;

  // result kinds
  localparam logic KIND_RUN = 1'b0;
  localparam logic KIND_END = 1'b1;

  localparam int unsigned CMD_FIFO_DEPTH = 2;

  typedef enum logic [1:0] {
    OP_RUN,
    OP_SKIP,
    OP_ROW,
    OP_END
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e op;
    logic    restart; // cursor goes back to the origin before this command
  } cmd_ctl_t;

  typedef struct packed {
    logic [7:0] symbol;
    logic       start_req;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [9:0]  run_row;
    logic [9:0]  run_col;
    logic [10:0] run_length;
    logic        clipped;
  } out_item_t;

endpackage

`default_nettype wire

// File: design/rcpd_chan_if.sv
// Valid/ready channel carrying one payload per beat.
// Payload type is a parameter; no other dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface rcpd_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: design/rle_cell_pattern_decoder_core.sv
// Top level of the RLE cell pattern body decoder.
// Depends on rcpd_pkg, rcpd_chan_if, rcpd_front, rcpd_cmd_fifo, rcpd_back.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir   Handshake      Beat content
// in_ch     in    valid/ready    symbol byte, start_req
// out_ch    out   valid/ready    kind, run_row, run_col, run_length, clipped
// cfg       in    cfg_we_i only  index 0 board_width, index 1 board_height
//
// One character per cycle while the queue has room; the back takes one command a cycle
// while its output slot is free. A tag's result passes queue write, then output register.
// Digits and unknown bytes stay in the front and never reach the queue.
// in_ch.ready drops only when the two-entry command queue is full; out_ch stalls back up
// through the queue, so either side can stall alone. No clearing pass after reset.

module rle_cell_pattern_decoder_core #(
  parameter int MAX_SIDE   = 1024,
  parameter int COUNT_BITS = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_we_i,
  input  wire         cfg_addr_i,
  input  wire  [10:0] cfg_wdata_i,
  rcpd_chan_if.sink   in_ch,
  rcpd_chan_if.source out_ch
);

  localparam int CmdW = $bits(rcpd_pkg::cmd_ctl_t) + COUNT_BITS;

  // board size registers; the user must write them only while the decoder is idle; the block does not enforce this
  logic [10:0] board_width_q, board_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      board_width_q  <= rcpd_pkg::SIDE_RESET;
      board_height_q <= rcpd_pkg::SIDE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        rcpd_pkg::CFG_BOARD_WIDTH:  board_width_q  <= cfg_wdata_i;
        rcpd_pkg::CFG_BOARD_HEIGHT: board_height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // front -> queue
  logic                  in_ready;
  logic                  fifo_full;
  logic                  push;
  rcpd_pkg::cmd_ctl_t    push_ctl;
  logic [COUNT_BITS-1:0] push_count;

  // queue -> back
  logic                  cmd_valid;
  logic                  cmd_pop;
  logic [CmdW-1:0]       cmd_word;
  rcpd_pkg::cmd_ctl_t    cmd_ctl;
  logic [COUNT_BITS-1:0] cmd_count;

  // back -> output channel
  logic                  out_valid;
  rcpd_pkg::out_item_t   out_item;

  rcpd_front #(
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_ch.payload),
    .fifo_full_i (fifo_full),
    .push_o      (push),
    .cmd_ctl_o   (push_ctl),
    .cmd_count_o (push_count)
  );

  assign in_ch.ready = in_ready;

  rcpd_cmd_fifo #(
    .WIDTH (CmdW)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i ({push_ctl, push_count}),
    .full_o  (fifo_full),
    .pop_i   (cmd_pop),
    .valid_o (cmd_valid),
    .rdata_o (cmd_word)
  );

  assign cmd_ctl   = rcpd_pkg::cmd_ctl_t'(cmd_word[CmdW-1:COUNT_BITS]);
  assign cmd_count = cmd_word[COUNT_BITS-1:0];

  rcpd_back #(
    .MAX_SIDE   (MAX_SIDE),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (cmd_valid),
    .cmd_ctl_i      (cmd_ctl),
    .cmd_count_i    (cmd_count),
    .cmd_pop_o      (cmd_pop),
    .board_width_i  (board_width_q),
    .board_height_i (board_height_q),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ch.ready),
    .out_item_o     (out_item)
  );

  assign out_ch.valid   = out_valid;
  assign out_ch.payload = out_item;

endmodule

`default_nettype wire

// File: design/rcpd_front.sv
// Front end: takes characters, builds the run count, issues tag commands.
// Depends on rcpd_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "rle_cell_pattern_decoder_core_assert.svh"

module rcpd_front #(
  parameter int COUNT_BITS = 16
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    in_valid_i,
  output logic                   in_ready_o,
  input  wire rcpd_pkg::in_item_t in_item_i,
  input  wire                    fifo_full_i,
  output logic                   push_o,
  output rcpd_pkg::cmd_ctl_t     cmd_ctl_o,
  output logic [COUNT_BITS-1:0]  cmd_count_o
);

  localparam int ProdW = COUNT_BITS + 4;
  localparam logic [ProdW-1:0] CountMax = ProdW'({COUNT_BITS{1'b1}});

  logic [COUNT_BITS-1:0] count_q, count_d, count_b;
  logic seen_q, seen_d, seen_b;
  logic finished_q, finished_d, fin_b;
  logic restart_q, restart_d, restart_b;

  logic                  in_fire;
  logic                  is_digit;
  logic                  is_tag;
  logic [7:0]            sym_off;
  logic [ProdW-1:0]      prod;
  rcpd_pkg::cmd_op_e     op;

  assign in_ready_o = !fifo_full_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign sym_off    = in_item_i.symbol - rcpd_pkg::CHAR_0;
  assign is_digit   = (in_item_i.symbol >= rcpd_pkg::CHAR_0) &&
                      (in_item_i.symbol <= rcpd_pkg::CHAR_9);

  always_comb begin
    is_tag = 1'b1;
    op     = rcpd_pkg::OP_SKIP;
    case (in_item_i.symbol)
      rcpd_pkg::CHAR_RUN:  op = rcpd_pkg::OP_RUN;
      rcpd_pkg::CHAR_SKIP: op = rcpd_pkg::OP_SKIP;
      rcpd_pkg::CHAR_ROW:  op = rcpd_pkg::OP_ROW;
      rcpd_pkg::CHAR_END:  op = rcpd_pkg::OP_END;
      default:             is_tag = 1'b0;
    endcase
  end

  always_comb begin
    // a start clears everything before the symbol itself is decoded
    count_b   = count_q;
    seen_b    = seen_q;
    fin_b     = finished_q;
    restart_b = restart_q;
    if (in_item_i.start_req) begin
      count_b   = '0;
      seen_b    = 1'b0;
      fin_b     = 1'b0;
      restart_b = 1'b1;
    end

    // count * 10 + digit
    prod = ProdW'({count_b, 3'b000}) + ProdW'({count_b, 1'b0}) + ProdW'(sym_off[3:0]);

    count_d     = count_q;
    seen_d      = seen_q;
    finished_d  = finished_q;
    restart_d   = restart_q;
    push_o      = 1'b0;
    cmd_ctl_o   = '{op: op, restart: restart_b};
    cmd_count_o = seen_b ? count_b : COUNT_BITS'(1);

    if (in_fire && !fin_b) begin
      finished_d = 1'b0;
      if (is_digit) begin
        count_d   = (prod > CountMax) ? CountMax[COUNT_BITS-1:0] : prod[COUNT_BITS-1:0];
        seen_d    = 1'b1;
        restart_d = restart_b;
      end else begin
        count_d = '0;
        seen_d  = 1'b0;
        if (is_tag) begin
          push_o     = 1'b1;
          restart_d  = 1'b0;
          finished_d = (op == rcpd_pkg::OP_END);
        end else begin
          restart_d = restart_b;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      seen_q     <= 1'b0;
      finished_q <= 1'b0;
      restart_q  <= 1'b0;
    end else begin
      count_q    <= count_d;
      seen_q     <= seen_d;
      finished_q <= finished_d;
      restart_q  <= restart_d;
    end
  end

  `RCPD_ASSERT_IMP(a_no_cmd_after_end, finished_q && in_fire && !in_item_i.start_req, !push_o, "command issued after end marker")
  `RCPD_ASSERT_NXT(a_end_sets_finished, push_o && op == rcpd_pkg::OP_END, finished_q, "end marker did not stop the front")

endmodule

`default_nettype wire

// File: design/rcpd_cmd_fifo.sv
// Short command queue between front and back; flop storage.
// Depends on rcpd_pkg for the depth.
`timescale 1ns / 1ps
`default_nettype none
`include "rle_cell_pattern_decoder_core_assert.svh"

module rcpd_cmd_fifo #(
  parameter int WIDTH = 19
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              push_i,
  input  wire  [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  wire              pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] rdata_o
);

  localparam int Depth = rcpd_pkg::CMD_FIFO_DEPTH;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  logic [WIDTH-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  `RCPD_ASSERT_IMP(a_no_pop_empty, pop_i, valid_o, "pop from empty command queue")
  `RCPD_ASSERT_NXT(a_push_grows, push_i && !pop_i, count_q == $past(count_q) + 1'b1, "queue count did not grow on push")

endmodule

`default_nettype wire

// File: design/rcpd_back.sv
// Back end: runs commands on the cursor, forms run/end results, output register.
// Depends on rcpd_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "rle_cell_pattern_decoder_core_assert.svh"

module rcpd_back #(
  parameter int MAX_SIDE   = 1024,
  parameter int COUNT_BITS = 16
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    cmd_valid_i,
  input  wire rcpd_pkg::cmd_ctl_t cmd_ctl_i,
  input  wire [COUNT_BITS-1:0]   cmd_count_i,
  output logic                   cmd_pop_o,
  input  wire  [10:0]            board_width_i,
  input  wire  [10:0]            board_height_i,
  output logic                   out_valid_o,
  input  wire                    out_ready_i,
  output rcpd_pkg::out_item_t    out_item_o
);

  localparam int SumW = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 1;
  localparam logic [16:0]     MaxSide   = 17'(MAX_SIDE);
  localparam logic [SumW-1:0] CursorMax = SumW'(17'h0FFFF);

  logic [15:0] row_q, row_d, col_q, col_d;
  logic        out_valid_q;
  rcpd_pkg::out_item_t out_q, out_d;

  logic [15:0]     row_b, col_b;
  logic [10:0]     eff_w, eff_h, avail;
  logic [SumW-1:0] cnt_x, col_sum, row_sum;
  logic [15:0]     col_sat, row_sat;
  logic            off_board, needs_out, slot_free, over;

  assign row_b = cmd_ctl_i.restart ? '0 : row_q;
  assign col_b = cmd_ctl_i.restart ? '0 : col_q;
  assign eff_w = (17'(board_width_i) > MaxSide) ? MaxSide[10:0] : board_width_i;
  assign eff_h = (17'(board_height_i) > MaxSide) ? MaxSide[10:0] : board_height_i;
  assign cnt_x = SumW'(cmd_count_i);

  assign col_sum = SumW'(col_b) + cnt_x;
  assign row_sum = SumW'(row_b) + cnt_x;
  assign col_sat = (col_sum > CursorMax) ? 16'hFFFF : col_sum[15:0];
  assign row_sat = (row_sum > CursorMax) ? 16'hFFFF : row_sum[15:0];

  assign off_board = (row_b >= 16'(eff_h)) || (col_b >= 16'(eff_w));
  assign avail     = eff_w - col_b[10:0];
  assign over      = cnt_x > SumW'(avail);

  assign needs_out = (cmd_ctl_i.op == rcpd_pkg::OP_RUN) || (cmd_ctl_i.op == rcpd_pkg::OP_END);
  assign slot_free = !out_valid_q || out_ready_i;
  assign cmd_pop_o = cmd_valid_i && (!needs_out || slot_free);

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    out_d = '0;
    if (cmd_ctl_i.op == rcpd_pkg::OP_RUN) begin
      out_d.kind = rcpd_pkg::KIND_RUN;
      if (off_board) begin
        out_d.clipped = 1'b1;
      end else begin
        out_d.run_row    = row_b[9:0];
        out_d.run_col    = col_b[9:0];
        out_d.run_length = over ? avail : cnt_x[10:0];
        out_d.clipped    = over;
      end
    end else begin
      out_d.kind = rcpd_pkg::KIND_END;
    end

    if (cmd_pop_o) begin
      case (cmd_ctl_i.op)
        rcpd_pkg::OP_RUN, rcpd_pkg::OP_SKIP: begin
          row_d = row_b;
          col_d = col_sat;
        end
        rcpd_pkg::OP_ROW: begin
          row_d = row_sat;
          col_d = '0;
        end
        default: begin
          row_d = row_b;
          col_d = col_b;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q       <= '0;
      col_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
      if (cmd_pop_o && needs_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o && needs_out) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `RCPD_ASSERT_IMP(a_end_fields_zero, out_valid_q && out_q.kind == rcpd_pkg::KIND_END, out_q.run_length == '0 && !out_q.clipped && out_q.run_row == '0, "end result carries run fields")
  `RCPD_ASSERT_NXT(a_row_monotonic, cmd_pop_o && !cmd_ctl_i.restart, row_q >= $past(row_q), "cursor row moved back without a start")

endmodule

`default_nettype wire

// File: verif/rcpd_result_checker.sv
// Result checker for the RLE cell pattern decoder: tracks config writes and input beats,
// predicts the run/end results and compares them with the output beats.
// Depends on rcpd_pkg.
`timescale 1ns / 1ps

module rcpd_result_checker
  import rcpd_pkg::*;
#(
  parameter int MAX_SIDE   = 1024,
  parameter int COUNT_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_addr_i,
  input  logic [10:0] cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  in_item_t    in_beat_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  out_item_t   out_beat_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned run_count_o,
  output int unsigned clip_count_o,
  output int unsigned end_count_o
);

  localparam logic [63:0] COUNT_LIMIT  = (64'd1 << COUNT_BITS) - 64'd1;
  localparam logic [63:0] SIDE_LIMIT   = 64'(MAX_SIDE);
  localparam logic [15:0] CURSOR_LIMIT = 16'hFFFF;

  logic [10:0] width_q;
  logic [10:0] height_q;
  logic [63:0] count_q;
  logic        count_seen_q;
  logic [15:0] row_q;
  logic [15:0] col_q;
  logic        finished_q;

  out_item_t   expected_runs[$];

  function automatic logic [15:0] sat_cursor(input logic [15:0] pos, input logic [63:0] amount);
    logic [63:0] sum;
    sum = {48'd0, pos} + amount;
    return (sum > {48'd0, CURSOR_LIMIT}) ? CURSOR_LIMIT : sum[15:0];
  endfunction

  task automatic clear_cursor();
    count_q      = '0;
    count_seen_q = 1'b0;
    row_q        = '0;
    col_q        = '0;
    finished_q   = 1'b0;
  endtask

  task automatic decode_symbol(input in_item_t beat);
    logic [63:0] grown;
    logic [63:0] cnt;
    logic [63:0] w;
    logic [63:0] h;
    logic [63:0] avail;
    logic [63:0] len;
    out_item_t   res;
    if (beat.start_req) clear_cursor();
    if (finished_q) return;
    if (beat.symbol >= CHAR_0 && beat.symbol <= CHAR_9) begin
      grown = count_q * 64'd10 + {56'd0, beat.symbol} - {56'd0, CHAR_0};
      count_q      = (grown > COUNT_LIMIT) ? COUNT_LIMIT : grown;
      count_seen_q = 1'b1;
      return;
    end
    // every tag, known or not, consumes the pending count
    cnt          = count_seen_q ? count_q : 64'd1;
    count_q      = '0;
    count_seen_q = 1'b0;
    res          = '0;
    case (beat.symbol)
      CHAR_RUN: begin
        w = ({53'd0, width_q} > SIDE_LIMIT) ? SIDE_LIMIT : {53'd0, width_q};
        h = ({53'd0, height_q} > SIDE_LIMIT) ? SIDE_LIMIT : {53'd0, height_q};
        res.kind = KIND_RUN;
        if ({48'd0, row_q} >= h || {48'd0, col_q} >= w) begin
          res.clipped = 1'b1;
        end else begin
          avail          = w - {48'd0, col_q};
          len            = (cnt > avail) ? avail : cnt;
          res.run_row    = row_q[9:0];
          res.run_col    = col_q[9:0];
          res.run_length = len[10:0];
          res.clipped    = (cnt > avail);
        end
        expected_runs = {expected_runs, res};
        col_q = sat_cursor(col_q, cnt);
      end
      CHAR_SKIP: col_q = sat_cursor(col_q, cnt);
      CHAR_ROW: begin
        row_q = sat_cursor(row_q, cnt);
        col_q = '0;
      end
      CHAR_END: begin
        finished_q = 1'b1;
        res.kind   = KIND_END;
        expected_runs = {expected_runs, res};
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count_o++;
    end
  endtask

  task automatic compare_result(input out_item_t got);
    out_item_t want;
    if (expected_runs.size() == 0) begin
      $error("result beat with nothing expected: kind %0d row %0d col %0d len %0d clip %0d",
             got.kind, got.run_row, got.run_col, got.run_length, got.clipped);
      fail_count_o++;
      return;
    end
    want = expected_runs.pop_front();
    check_field("kind", want.kind, got.kind);
    check_field("run_row", want.run_row, got.run_row);
    check_field("run_col", want.run_col, got.run_col);
    check_field("run_length", want.run_length, got.run_length);
    check_field("clipped", want.clipped, got.clipped);
    if (want.kind == KIND_END) begin
      end_count_o++;
    end else begin
      run_count_o++;
      if (want.clipped) clip_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  = SIDE_RESET;
      height_q = SIDE_RESET;
      clear_cursor();
      expected_runs.delete();
      fail_count_o = 0;
      pending_o    = 0;
      run_count_o  = 0;
      clip_count_o = 0;
      end_count_o  = 0;
    end else begin
      if (out_valid_i && out_ready_i) compare_result(out_beat_i);
      if (in_valid_i && in_ready_i) decode_symbol(in_beat_i);
      if (cfg_we_i) begin
        if (cfg_addr_i == CFG_BOARD_WIDTH) width_q = cfg_wdata_i;
        else height_q = cfg_wdata_i;
      end
      pending_o = expected_runs.size();
    end
  end

endmodule

// File: verif/tb_rle_cell_pattern_decoder_core.sv
// Testbench top for rle_cell_pattern_decoder_core: drives pattern bodies, board settings
// and output back-pressure; prediction and comparison live in rcpd_result_checker.
// Depends on rcpd_pkg, rcpd_chan_if, rcpd_result_checker and the decoder RTL.
`timescale 1ns / 1ps

module tb_rle_cell_pattern_decoder_core;
  import rcpd_pkg::*;

  localparam int CLK_PERIOD      = 10;
  localparam int RESET_CYCLES    = 10;
  localparam int NUM_PHASES      = 8;
  localparam int PHASE_ITEMS     = 215;  // counted beats per board setting
  localparam int HOLD_OFF_PHASE  = 2;
  localparam int HOLD_OFF_CYCLES = 400;  // long receiver stall, fills the command queue
  localparam int SETTLE_CYCLES   = 4;    // queue write + output register, with margin
  localparam int DRAIN_LIMIT     = 3000;
  localparam int TAIL_CYCLES     = 8;
  localparam int WATCHDOG_LIMIT  = 5000; // cycles with no beat on any port

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  logic        cfg_addr;
  logic [10:0] cfg_wdata;

  rcpd_chan_if #(.payload_t(in_item_t))  in_ch ();
  rcpd_chan_if #(.payload_t(out_item_t)) out_ch ();

  int unsigned chk_fail_count;
  int unsigned chk_pending;
  int unsigned chk_run_count;
  int unsigned chk_clip_count;
  int unsigned chk_end_count;

  // beat-taken flag, sampled at the rising edge and read by the driver at the falling edge
  logic        in_acc;
  int unsigned idle_cycles;

  // stimulus bookkeeping
  bit          start_pending;  // next beat carries start_req
  bit          body_ended;     // '!' seen; beats without start are ignored until restart
  bit          tx_no_idle;     // current body goes out back to back
  bit          hold_off_req;
  int unsigned item_total;

  logic [10:0] phase_width[NUM_PHASES]  = '{11'd8, 11'd1, 11'd1024, 11'd0,
                                            11'd2047, 11'd40, 11'd1023, 11'd0};
  logic [10:0] phase_height[NUM_PHASES] = '{11'd6, 11'd1, 11'd1024, 11'd5,
                                            11'd2047, 11'd0, 11'd1000, 11'd0};

  rle_cell_pattern_decoder_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_addr_i (cfg_addr),
    .cfg_wdata_i(cfg_wdata),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

  rcpd_result_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_addr_i  (cfg_addr),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_ch.valid),
    .in_ready_i  (in_ch.ready),
    .in_beat_i   (in_ch.payload),
    .out_valid_i (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .out_beat_i  (out_ch.payload),
    .fail_count_o(chk_fail_count),
    .pending_o   (chk_pending),
    .run_count_o (chk_run_count),
    .clip_count_o(chk_clip_count),
    .end_count_o (chk_end_count)
  );

  initial clk_i = 1'b0;
  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Beat flag and watchdog. The watchdog only fires on a stuck design: every
  // legitimate stall (hold-off, long gaps, settle waits) is far below the limit.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_acc      <= 1'b0;
      idle_cycles <= 0;
    end else begin
      in_acc  <= in_ch.valid && in_ch.ready;
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", idle_cycles);
        $display("rle_cell_pattern_decoder_core: mismatch");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Gap lengths: mostly none or short, a few long.
  function automatic int unsigned pick_gap(input bit no_idle);
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Receiver: random ready stretches, now and then a long run with no stall, and one
  // long hold-off (on request) while the sender keeps offering beats.
  initial begin : rx_ready_gen
    bit          held;
    int unsigned high_len;
    int unsigned low_len;
    held         = 1'b0;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_off_req && !held) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk_i);
      end else begin
        high_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 8);
        low_len  = pick_gap(1'b0);
        out_ch.ready <= 1'b1;
        repeat (high_len) @(negedge clk_i);
        if (low_len != 0) begin
          out_ch.ready <= 1'b0;
          repeat (low_len) @(negedge clk_i);
        end
      end
    end
  end

  // Sends one beat; entered and left at a falling edge. Valid stays high on exit so a
  // following beat with no gap goes out on the next edge.
  task automatic send_sym(input logic [7:0] sym);
    int unsigned gap;
    bit          start;
    gap           = pick_gap(tx_no_idle);
    start         = start_pending;
    start_pending = 1'b0;
    if (start) body_ended = 1'b0;
    if (!body_ended) begin
      item_total++;
      if (sym == CHAR_END) body_ended = 1'b1;
    end
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= '{symbol: sym, start_req: start};
    do @(negedge clk_i); while (!in_acc);
  endtask

  // Decimal count, most significant digit first.
  task automatic send_num(input int unsigned value);
    logic [7:0] digit_syms[$];
    do begin
      digit_syms.push_front(8'(CHAR_0 + value % 10));
      value = value / 10;
    end while (value != 0);
    foreach (digit_syms[i]) send_sym(digit_syms[i]);
  endtask

  // Optional count in front of a tag: mostly none or small, some leading zeros,
  // a few large enough to clip runs and saturate the count and cursor.
  task automatic send_random_count();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return;
    if (r < 75) send_num($urandom_range(1, 9));
    else if (r < 90) send_num($urandom_range(10, 99));
    else if (r < 94) send_num(0);
    else if (r < 97) begin
      send_num(0);
      send_num($urandom_range(1, 9));
    end else send_num($urandom_range(100, 99999));
  endtask

  // Random byte, sometimes with a restart in the middle of a body.
  task automatic send_noise();
    if ($urandom_range(0, 15) == 0) start_pending = 1'b1;
    send_sym(8'($urandom_range(0, 255)));
  endtask

  // One body: rows of counted 'o'/'b' tags separated by counted '$', ended by '!'.
  // Some bodies are cut short, some carry junk after the end marker.
  task automatic send_body();
    int unsigned rows;
    int unsigned tokens;
    int unsigned r;
    tx_no_idle    = ($urandom_range(0, 9) == 0);
    start_pending = 1'b1;
    rows          = $urandom_range(1, 4);
    for (int unsigned row = 0; row < rows; row++) begin
      tokens = $urandom_range(1, 5);
      for (int unsigned t = 0; t < tokens; t++) begin
        if ($urandom_range(0, 14) == 0) send_noise();
        send_random_count();
        send_sym($urandom_range(0, 2) != 0 ? CHAR_RUN : CHAR_SKIP);
      end
      if (row + 1 < rows) begin
        send_random_count();
        send_sym(CHAR_ROW);
      end
    end
    r = $urandom_range(0, 9);
    if (r < 8) begin
      send_sym(CHAR_END);
    end else if (r == 9) begin
      send_sym(CHAR_END);
      repeat ($urandom_range(1, 3)) send_noise();
    end
  endtask

  // Stops input and waits for the last result, then for the pipeline to empty.
  task automatic wait_idle();
    int unsigned waited;
    waited = 0;
    in_ch.valid <= 1'b0;
    while (chk_pending != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_board(input logic [10:0] width, input logic [10:0] height);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_BOARD_WIDTH;
    cfg_wdata <= width;
    @(negedge clk_i);
    cfg_addr  <= CFG_BOARD_HEIGHT;
    cfg_wdata <= height;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  initial begin : stimulus
    int unsigned phase_start;
    int unsigned fails;
    rst_ni        = 1'b0;
    cfg_we        = 1'b0;
    cfg_addr      = CFG_BOARD_WIDTH;
    cfg_wdata     = '0;
    in_ch.valid   = 1'b0;
    in_ch.payload = '0;
    start_pending = 1'b0;
    body_ended    = 1'b0;
    tx_no_idle    = 1'b0;
    hold_off_req  = 1'b0;
    item_total    = 0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed body on the reset board (1024 x 1024).
    start_pending = 1'b1;
    send_num(3);                  // body starts on a digit
    send_sym(CHAR_RUN);
    send_sym(CHAR_SKIP);          // no digits: count of one
    send_num(2);
    send_sym(CHAR_ROW);
    send_num(0);
    send_sym(CHAR_RUN);           // empty run, not clipped
    send_num(0);
    send_sym(CHAR_SKIP);          // zero skip and zero row keep the cursor
    send_num(0);
    send_sym(CHAR_ROW);
    send_num(5);
    send_sym(8'hFF);              // unknown byte drops the count
    send_sym(CHAR_RUN);
    send_num(99999);              // count saturates, run cut at the right edge
    send_sym(CHAR_RUN);
    send_sym(CHAR_RUN);           // column past the edge: wholly off the board
    send_num(99999);
    send_sym(CHAR_ROW);           // row cursor saturates
    send_sym(CHAR_RUN);           // row below the board
    send_sym(CHAR_END);
    send_sym(CHAR_RUN);           // ignored after the end marker
    start_pending = 1'b1;
    send_sym(8'h00);              // restart on a byte that is no tag
    send_sym(CHAR_END);

    // Random bodies, one phase per board setting. The last setting is random; the
    // others cover tiny, zero-sized, oversized and full boards.
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      if (p == NUM_PHASES - 1) begin
        phase_width[p]  = 11'($urandom_range(1, 1024));
        phase_height[p] = 11'($urandom_range(1, 1024));
      end
      set_board(phase_width[p], phase_height[p]);
      if (p == HOLD_OFF_PHASE) hold_off_req <= 1'b1;
      phase_start = item_total;
      while (item_total - phase_start < PHASE_ITEMS) send_body();
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(negedge clk_i);
    fails = chk_fail_count + chk_pending;
    if (chk_pending != 0) $error("%0d results never arrived", chk_pending);

    $display("Run covered %0d decoded symbols over %0d board settings and one %0d-cycle stall.",
             item_total, NUM_PHASES + 1, HOLD_OFF_CYCLES);
    $display("Checked %0d runs (%0d clipped) and %0d end markers.",
             chk_run_count, chk_clip_count, chk_end_count);
    if (fails == 0) begin
      $display("rle_cell_pattern_decoder_core: match");
    end else begin
      $display("rle_cell_pattern_decoder_core: mismatch");
    end
    $finish;
  end

endmodule
